// ----- rtl/tes_pkg.sv -----
package tes_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned NCOORD      = 6;
  localparam int unsigned NLANE       = 6;
  localparam int unsigned K_W         = 32;
  localparam int unsigned LOAD_W      = 39;
  localparam int unsigned LOAD_FRAC   = 8;
  localparam int unsigned LOAD_STEP   = 8;
  localparam int unsigned QUOT_BITS   = 33;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned OUT_DATA_W = ((NLANE * K_W + LOAD_W + 7) / 8) * 8;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  localparam logic [2:0]        LOAD_DIV = 3'd3;

  // coordinate order in the input word
  localparam int unsigned IDX_XA = 0;
  localparam int unsigned IDX_YA = 1;
  localparam int unsigned IDX_XB = 2;
  localparam int unsigned IDX_YB = 3;
  localparam int unsigned IDX_XC = 4;
  localparam int unsigned IDX_YC = 5;

  // node pairs of the upper triangle: aa ab ac bb bc cc
  localparam int LANE_I [NLANE] = '{0, 0, 0, 1, 1, 2};
  localparam int LANE_J [NLANE] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic full;
    logic valid;
  } tes_qstat_t;

endpackage

// ----- rtl/tes_front.sv -----
module tes_front #(
  parameter int unsigned COORD_BITS = tes_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tes_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W = ((tes_pkg::NCOORD * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned NW   = 2 * COORD_BITS + 3,
  localparam int unsigned RW   = NW + 1,
  localparam int unsigned IW   = tes_pkg::NLANE * (NW + 2) + RW + NW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [IN_W-1:0] in_data_i,
  input  logic            full_i,
  output logic            out_valid_o,
  output logic [IW-1:0]   out_data_o
);

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned SH  = 32 - FRAC_BITS;
  localparam int unsigned LIW = NW + 2;

  logic adv;
  logic vld_a_q, vld_b_q;

  logic signed [COORD_BITS-1:0] crd [tes_pkg::NCOORD];
  logic signed [DW-1:0] bd_q [3];
  logic signed [DW-1:0] cd_q [3];
  logic signed [PW-1:0] pd1_q, pd2_q;
  logic signed [PW-1:0] bb_q [tes_pkg::NLANE];
  logic signed [PW-1:0] cc_q [tes_pkg::NLANE];

  assign adv        = !vld_b_q || !full_i;
  assign in_ready_o = adv;

  always_comb begin
    for (int k = 0; k < tes_pkg::NCOORD; k++) begin
      crd[k] = in_data_i[k*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= in_valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  // edge terms, then products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bd_q[0] <= DW'(crd[tes_pkg::IDX_YB]) - DW'(crd[tes_pkg::IDX_YC]);
      bd_q[1] <= DW'(crd[tes_pkg::IDX_YC]) - DW'(crd[tes_pkg::IDX_YA]);
      bd_q[2] <= DW'(crd[tes_pkg::IDX_YA]) - DW'(crd[tes_pkg::IDX_YB]);
      cd_q[0] <= DW'(crd[tes_pkg::IDX_XC]) - DW'(crd[tes_pkg::IDX_XB]);
      cd_q[1] <= DW'(crd[tes_pkg::IDX_XA]) - DW'(crd[tes_pkg::IDX_XC]);
      cd_q[2] <= DW'(crd[tes_pkg::IDX_XB]) - DW'(crd[tes_pkg::IDX_XA]);
      pd1_q   <= PW'(cd_q[2]) * PW'(bd_q[1]);
      pd2_q   <= PW'(cd_q[1]) * PW'(bd_q[2]);
      for (int k = 0; k < tes_pkg::NLANE; k++) begin
        bb_q[k] <= PW'(bd_q[tes_pkg::LANE_I[k]]) * PW'(bd_q[tes_pkg::LANE_J[k]]);
        cc_q[k] <= PW'(cd_q[tes_pkg::LANE_I[k]]) * PW'(cd_q[tes_pkg::LANE_J[k]]);
      end
    end
  end

  // det, numerators, magnitudes and overrange flags
  always_comb begin
    logic signed [NW-1:0] det;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        adet;
    logic [NW-1:0]        mag;
    logic [RW-1:0]        den;
    logic [RW+SH-1:0]     lim;
    det  = NW'(pd1_q) - NW'(pd2_q);
    adet = det[NW-1] ? NW'(-det) : NW'(det);
    den  = {adet, 1'b0};
    lim  = {den, {SH{1'b0}}};
    for (int k = 0; k < tes_pkg::NLANE; k++) begin
      num = NW'(bb_q[k]) + NW'(cc_q[k]);
      mag = num[NW-1] ? NW'(-num) : NW'(num);
      out_data_o[k*LIW +: LIW] = {num[NW-1], ((RW+SH)'(mag) >= lim), mag};
    end
    out_data_o[tes_pkg::NLANE*LIW +: RW]      = den;
    out_data_o[tes_pkg::NLANE*LIW + RW +: NW] = adet;
    out_data_o[IW-1]                          = (det == '0);
  end

  assign out_valid_o = vld_b_q;

endmodule

// ----- rtl/tes_queue.sv -----
module tes_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = tes_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [W-1:0]       data_i,
  input  logic               pop_i,
  output tes_pkg::tes_qstat_t stat_o,
  output logic [W-1:0]       data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/tes_back.sv -----
module tes_back #(
  parameter int unsigned COORD_BITS = tes_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tes_pkg::FRAC_BITS_DEF,
  localparam int unsigned NW = 2 * COORD_BITS + 3,
  localparam int unsigned RW = NW + 1,
  localparam int unsigned IW = tes_pkg::NLANE * (NW + 2) + RW + NW + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [IW-1:0]                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tes_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                            out_degen_o
);

  localparam int unsigned SH  = 32 - FRAC_BITS;
  localparam int unsigned LIW = NW + 2;
  localparam int unsigned QB  = tes_pkg::QUOT_BITS;
  localparam int unsigned NL  = tes_pkg::NLANE;
  localparam int unsigned LW  = NW + tes_pkg::LOAD_FRAC - 1;
  localparam int unsigned LCH = (LW + tes_pkg::LOAD_STEP - 1) / tes_pkg::LOAD_STEP;
  localparam int unsigned LSW = LCH * tes_pkg::LOAD_STEP;
  localparam int unsigned XW  = LSW + tes_pkg::LOAD_W;

  logic adv;

  // one quotient bit per stage
  logic          vld_q   [QB];
  logic [RW-1:0] r_q     [QB][NL];
  logic [QB-1:0] s_q     [QB][NL];
  logic          neg_q   [QB][NL];
  logic          sat_q   [QB][NL];
  logic [RW-1:0] den_q   [QB];
  logic          degen_q [QB];
  logic [LSW-1:0] ln_q   [QB];
  logic [1:0]     lr_q   [QB];

  logic                           out_vld_q;
  logic [tes_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                           out_degen_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic          v_in;
    logic [RW-1:0] r_in   [NL];
    logic [QB-1:0] s_in   [NL];
    logic          neg_in [NL];
    logic          sat_in [NL];
    logic [RW-1:0] den_in;
    logic          degen_in;
    logic [LSW-1:0] ln_in;
    logic [1:0]     lr_in;
    logic [RW-1:0] r_d [NL];
    logic [QB-1:0] s_d [NL];
    logic [LSW-1:0] ln_d;
    logic [1:0]     lr_d;

    if (g == 0) begin : g_head
      always_comb begin
        logic [NW+SH-1:0] magx;
        logic [NW-1:0]    adet;
        v_in     = in_valid_i;
        den_in   = in_data_i[NL*LIW +: RW];
        adet     = in_data_i[NL*LIW + RW +: NW];
        degen_in = in_data_i[IW-1];
        ln_in    = LSW'({adet, {(tes_pkg::LOAD_FRAC-1){1'b0}}}) | LSW'(1);
        lr_in    = '0;
        for (int k = 0; k < NL; k++) begin
          magx      = (NW+SH)'(in_data_i[k*LIW +: NW]);
          sat_in[k] = in_data_i[k*LIW + NW];
          neg_in[k] = in_data_i[k*LIW + NW + 1];
          r_in[k]   = RW'(magx >> SH);
          s_in[k]   = {magx[SH-1:0], {(FRAC_BITS+1){1'b0}}};
        end
      end
    end else begin : g_tail
      always_comb begin
        v_in     = vld_q[g-1];
        den_in   = den_q[g-1];
        degen_in = degen_q[g-1];
        ln_in    = ln_q[g-1];
        lr_in    = lr_q[g-1];
        for (int k = 0; k < NL; k++) begin
          r_in[k]   = r_q[g-1][k];
          s_in[k]   = s_q[g-1][k];
          neg_in[k] = neg_q[g-1][k];
          sat_in[k] = sat_q[g-1][k];
        end
      end
    end

    // restoring step; remainder stays below den
    always_comb begin
      logic [RW:0] r2;
      logic        ge;
      logic [2:0]  lt;
      logic        lge;
      for (int k = 0; k < NL; k++) begin
        r2     = {r_in[k], s_in[k][QB-1]};
        ge     = (r2 >= (RW+1)'(den_in));
        r_d[k] = ge ? RW'(r2 - (RW+1)'(den_in)) : RW'(r2);
        s_d[k] = {s_in[k][QB-2:0], ge};
      end
      ln_d = ln_in;
      lr_d = lr_in;
      if (g < LCH) begin
        for (int t = 0; t < tes_pkg::LOAD_STEP; t++) begin
          lt   = {lr_d, ln_d[LSW-1]};
          lge  = (lt >= tes_pkg::LOAD_DIV);
          lr_d = lge ? 2'(lt - tes_pkg::LOAD_DIV) : lt[1:0];
          ln_d = {ln_d[LSW-2:0], lge};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv) begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        den_q[g]   <= den_in;
        degen_q[g] <= degen_in;
        ln_q[g]    <= ln_d;
        lr_q[g]    <= lr_d;
        for (int k = 0; k < NL; k++) begin
          r_q[g][k]   <= r_d[k];
          s_q[g][k]   <= s_d[k];
          neg_q[g][k] <= neg_in[k];
          sat_q[g][k] <= sat_in[k];
        end
      end
    end
  end

  // round magnitude half up, clamp, apply sign; all fields zero if degenerate
  always_comb begin
    logic [QB:0]              rnd;
    logic [QB-1:0]            lim;
    logic [QB-1:0]            mv;
    logic [tes_pkg::K_W-1:0]  kv;
    logic [XW-1:0]            lx;
    logic [tes_pkg::LOAD_W-1:0] lv;
    out_data_d = '0;
    for (int k = 0; k < NL; k++) begin
      rnd = ((QB+1)'(s_q[QB-1][k]) + (QB+1)'(1)) >> 1;
      lim = QB'(1) << (tes_pkg::K_W - 1);
      if (!neg_q[QB-1][k]) begin
        lim = lim - 1'b1;
      end
      mv = (sat_q[QB-1][k] || (rnd > (QB+1)'(lim))) ? lim : rnd[QB-1:0];
      kv = neg_q[QB-1][k] ? tes_pkg::K_W'(~mv + 1'b1) : tes_pkg::K_W'(mv);
      out_data_d[k*tes_pkg::K_W +: tes_pkg::K_W] = kv;
    end
    lx = XW'(ln_q[QB-1]);
    lv = (lx > XW'(tes_pkg::LOAD_MAX)) ? tes_pkg::LOAD_MAX : lx[tes_pkg::LOAD_W-1:0];
    out_data_d[NL*tes_pkg::K_W +: tes_pkg::LOAD_W] = lv;
    if (degen_q[QB-1]) begin
      out_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q  <= out_data_d;
      out_degen_q <= degen_q[QB-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_degen_o = out_degen_q;

endmodule

// ----- rtl/triangle_element_stiffness.sv -----
// Channel  | Dir | Word                                   | Notes
// s_axis   | in  | tdata: x_a y_a x_b y_b x_c y_c         | COORD_BITS each, signed
// m_axis   | out | tdata: k_aa k_ab k_ac k_bb k_bc k_cc,  | 32b Q15.16 each, then
//          |     |        load_share; tuser: degenerate   | 39b Q.8, zero pad
//
// One triangle word accepted per cycle while s_axis_tready_o is high, one
// result word per triangle, in order. Path through an empty block: two front
// stages (edge terms, products), the queue, 33 divider stages (one quotient
// bit of the six stiffness lanes per stage) and the output register.
// Reset clears valid bits, queue pointers and count only; payload is not reset.
// A stall on m_axis freezes the divider; the front keeps taking words until
// the two-entry queue fills, then drops s_axis_tready_o.
module triangle_element_stiffness #(
  parameter int unsigned COORD_BITS = tes_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tes_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W = ((tes_pkg::NCOORD * COORD_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // x_a, y_a, x_b, y_b, x_c, y_c from bit 0 up
  input  logic [IN_W-1:0]                s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // k_aa, k_ab, k_ac, k_bb, k_bc, k_cc, load_share from bit 0 up, zero pad
  output logic [tes_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // degenerate
  output logic [0:0]                     m_axis_tuser_o
);

  localparam int unsigned NW = 2 * COORD_BITS + 3;
  localparam int unsigned IW = tes_pkg::NLANE * (NW + 2) + (NW + 1) + NW + 1;

  logic                f_valid;
  logic [IW-1:0]       f_data;
  logic [IW-1:0]       q_data;
  logic                b_ready;
  tes_pkg::tes_qstat_t q_stat;

  // front: edge terms, products, det and per-lane magnitudes
  tes_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .full_i     (q_stat.full),
    .out_valid_o(f_valid),
    .out_data_o (f_data)
  );

  tes_queue #(
    .W    (IW),
    .DEPTH(tes_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(f_valid),
    .data_i(f_data),
    .pop_i (b_ready),
    .stat_o(q_stat),
    .data_o(q_data)
  );

  // back: pipelined divide, rounding, saturation, output register
  tes_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_stat.valid),
    .in_ready_o (b_ready),
    .in_data_i  (q_data),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_degen_o(m_axis_tuser_o[0])
  );

endmodule

// ----- rtl/tes_checker.sv -----
module tes_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [tes_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                     m_axis_tuser_o
);

  localparam int unsigned KW = tes_pkg::K_W;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result word shown in reset");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("degenerate triangle with non-zero fields");

  a_diag_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      !m_axis_tdata_o[KW-1] && !m_axis_tdata_o[4*KW-1] && !m_axis_tdata_o[6*KW-1])
    else $error("negative diagonal stiffness entry");

endmodule

bind triangle_element_stiffness tes_checker u_tes_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

// ----- sim/triangle_element_stiffness_tb.sv -----
module triangle_element_stiffness_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB         = tes_pkg::COORD_BITS_DEF;
  localparam int unsigned FB         = tes_pkg::FRAC_BITS_DEF;
  localparam int unsigned NCOORD     = tes_pkg::NCOORD;
  localparam int unsigned NLANE      = tes_pkg::NLANE;
  localparam int unsigned K_W        = tes_pkg::K_W;
  localparam int unsigned LOAD_W     = tes_pkg::LOAD_W;
  localparam int unsigned LOAD_FRAC  = tes_pkg::LOAD_FRAC;
  localparam int unsigned OUT_DATA_W = tes_pkg::OUT_DATA_W;
  localparam logic [LOAD_W-1:0] LOAD_MAX = tes_pkg::LOAD_MAX;
  localparam int unsigned IN_W = ((NCOORD * CB + 7) / 8) * 8;
  // time through an empty block, plus a full queue and margin
  localparam int unsigned DRAIN_CYCLES = 80;
  // no acceptance for this long means the block has hung
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned N_RANDOM     = 1200;

  typedef struct packed {
    logic signed [CB-1:0] y_c;
    logic signed [CB-1:0] x_c;
    logic signed [CB-1:0] y_b;
    logic signed [CB-1:0] x_b;
    logic signed [CB-1:0] y_a;
    logic signed [CB-1:0] x_a;
  } tri_t;

  typedef struct packed {
    logic [LOAD_W-1:0] load_share;
    logic [K_W-1:0]    k_cc;
    logic [K_W-1:0]    k_bc;
    logic [K_W-1:0]    k_bb;
    logic [K_W-1:0]    k_ac;
    logic [K_W-1:0]    k_ab;
    logic [K_W-1:0]    k_aa;
    logic              degenerate;
  } stiff_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // x_a, y_a, x_b, y_b, x_c, y_c from bit 0 up
  logic [IN_W-1:0]       s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // k_aa, k_ab, k_ac, k_bb, k_bc, k_cc, load_share from bit 0 up, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // degenerate
  logic [0:0]            m_axis_tuser_o;

  always #4 clk_i = ~clk_i;

  triangle_element_stiffness #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  tri_t   tri_q[$];       // triangles waiting to be sent
  stiff_t stiff_q[$];     // predicted results, oldest first
  int     n_err = 0;
  int     n_sent = 0, n_got = 0, n_degen = 0, n_sat = 0;
  int     idle_cnt = 0;
  bit     stim_done = 1'b0;

  // entry = num * 2^FB / den, nearest, ties away from zero, saturated
  function automatic logic [K_W-1:0] q16_quot(longint num, longint unsigned den);
    bit               neg;
    longint unsigned  mag, lim, q, r, res;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
    q = mag / den;
    r = mag % den;
    if (q > ((64'd1 << 31) >> FB)) begin
      res = lim;
    end else begin
      res = q << FB;
      for (int k = FB - 1; k >= 0; k--) begin
        r = r << 1;
        if (r >= den) begin
          r -= den;
          res |= 64'd1 << k;
        end
      end
      r = r << 1;
      if (r >= den) res++;
      if (res > lim) res = lim;
    end
    if (neg) res = -res;
    return res[K_W-1:0];
  endfunction

  function automatic stiff_t element_stiffness(tri_t t);
    stiff_t          s;
    longint          xa, ya, xb, yb, xc, yc, det;
    longint          bv[3], cv[3];
    longint unsigned adet, load;
    logic [K_W-1:0]  k[6];
    xa = t.x_a; ya = t.y_a; xb = t.x_b; yb = t.y_b; xc = t.x_c; yc = t.y_c;
    s = '0;
    det = (xb - xa) * (yc - ya) - (xc - xa) * (yb - ya);
    if (det == 0) begin
      s.degenerate = 1'b1;
      return s;
    end
    bv[0] = yb - yc; bv[1] = yc - ya; bv[2] = ya - yb;
    cv[0] = xc - xb; cv[1] = xa - xc; cv[2] = xb - xa;
    adet = det < 0 ? -det : det;
    for (int n = 0; n < NLANE; n++)
      k[n] = q16_quot(bv[tes_pkg::LANE_I[n]] * bv[tes_pkg::LANE_J[n]] +
                      cv[tes_pkg::LANE_I[n]] * cv[tes_pkg::LANE_J[n]],
                      adet << 1);
    s.k_aa = k[0]; s.k_ab = k[1]; s.k_ac = k[2];
    s.k_bb = k[3]; s.k_bc = k[4]; s.k_cc = k[5];
    load = ((adet << LOAD_FRAC) + 3) / 6;
    s.load_share = load > LOAD_MAX ? LOAD_MAX : load[LOAD_W-1:0];
    return s;
  endfunction

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0:       return CB'($urandom);                                   // full range
      1:       return CB'($signed(CB'($urandom_range(0, 64))) - 32);   // tiny
      2:       return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return CB'($signed(CB'($urandom_range(0, 2000))) - 1000);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int   m;
    m = $urandom_range(0, 9);
    t.x_a = rand_coord(m < 3 ? 0 : m < 6 ? 1 : m == 6 ? 2 : 3);
    t.y_a = rand_coord(m < 3 ? 0 : m < 6 ? 1 : m == 6 ? 2 : 3);
    t.x_b = rand_coord(m < 3 ? 0 : m < 6 ? 1 : m == 6 ? 2 : 3);
    t.y_b = rand_coord(m < 3 ? 0 : m < 6 ? 1 : m == 6 ? 2 : 3);
    case ($urandom_range(0, 7))
      0: begin // collinear: c on line through a and b
        t.x_c = t.x_b + (t.x_b - t.x_a);
        t.y_c = t.y_b + (t.y_b - t.y_a);
      end
      1: begin // repeated corner
        t.x_c = t.x_a;
        t.y_c = t.y_a;
      end
      2: begin // sliver: near collinear, large entries
        t.x_c = CB'(t.x_b + (t.x_b - t.x_a) + CB'($urandom_range(0, 1)));
        t.y_c = t.y_b + (t.y_b - t.y_a);
      end
      default: begin
        t.x_c = rand_coord(m < 3 ? 0 : m < 6 ? 1 : m == 6 ? 2 : 3);
        t.y_c = rand_coord(m < 3 ? 0 : m < 6 ? 1 : m == 6 ? 2 : 3);
      end
    endcase
    return t;
  endfunction

  function automatic tri_t mk_tri(int xa, int ya, int xb, int yb, int xc, int yc);
    tri_t t;
    t.x_a = CB'(xa); t.y_a = CB'(ya); t.x_b = CB'(xb);
    t.y_b = CB'(yb); t.x_c = CB'(xc); t.y_c = CB'(yc);
    return t;
  endfunction

  // driver: word held until accepted, random gap before each word
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        stiff_q.push_back(element_stiffness(tri_t'(s_axis_tdata_i[NCOORD*CB-1:0])));
        n_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_gap > 0 || tri_q.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
          if (tx_gap > 0) tx_gap <= tx_gap - 1;
        end else begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= IN_W'(tri_q.pop_front());
          tx_gap          <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        end
      end
    end
  end

  // monitor: random back-pressure, each word checked against the oldest prediction
  int rx_wait = 0;
  always @(posedge clk_i) begin
    stiff_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '0;
        got.k_aa       = m_axis_tdata_o[0*K_W +: K_W];
        got.k_ab       = m_axis_tdata_o[1*K_W +: K_W];
        got.k_ac       = m_axis_tdata_o[2*K_W +: K_W];
        got.k_bb       = m_axis_tdata_o[3*K_W +: K_W];
        got.k_bc       = m_axis_tdata_o[4*K_W +: K_W];
        got.k_cc       = m_axis_tdata_o[5*K_W +: K_W];
        got.load_share = m_axis_tdata_o[NLANE*K_W +: LOAD_W];
        got.degenerate = m_axis_tuser_o[0];
        n_got++;
        if (stiff_q.size() == 0) begin
          $error("unexpected result word");
          n_err++;
        end else begin
          exp_r = stiff_q.pop_front();
          if (exp_r.degenerate) n_degen++;
          if (exp_r.k_aa == 32'h7fffffff || exp_r.k_ab == 32'h80000000 ||
              exp_r.k_ab == 32'h7fffffff) n_sat++;
          if (got.k_aa !== exp_r.k_aa) begin
            $error("k_aa: expected %h, got %h", exp_r.k_aa, got.k_aa); n_err++;
          end
          if (got.k_ab !== exp_r.k_ab) begin
            $error("k_ab: expected %h, got %h", exp_r.k_ab, got.k_ab); n_err++;
          end
          if (got.k_ac !== exp_r.k_ac) begin
            $error("k_ac: expected %h, got %h", exp_r.k_ac, got.k_ac); n_err++;
          end
          if (got.k_bb !== exp_r.k_bb) begin
            $error("k_bb: expected %h, got %h", exp_r.k_bb, got.k_bb); n_err++;
          end
          if (got.k_bc !== exp_r.k_bc) begin
            $error("k_bc: expected %h, got %h", exp_r.k_bc, got.k_bc); n_err++;
          end
          if (got.k_cc !== exp_r.k_cc) begin
            $error("k_cc: expected %h, got %h", exp_r.k_cc, got.k_cc); n_err++;
          end
          if (got.load_share !== exp_r.load_share) begin
            $error("load_share: expected %h, got %h", exp_r.load_share, got.load_share);
            n_err++;
          end
          if (got.degenerate !== exp_r.degenerate) begin
            $error("degenerate: expected %b, got %b", exp_r.degenerate, got.degenerate);
            n_err++;
          end
        end
      end
      // new wait drawn after each taken word; long free-flowing runs too
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        rx_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready_i <= (rx_wait == 0);
    end
  end

  // watchdog on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    // directed: extremes, degenerate shapes, saturating slivers
    tri_q.push_back(mk_tri(0, 0, 1, 0, 0, 1));
    tri_q.push_back(mk_tri(0, 0, 0, 1, 1, 0));              // clockwise
    tri_q.push_back(mk_tri(0, 0, 0, 0, 0, 0));              // all same
    tri_q.push_back(mk_tri(1, 1, 2, 2, 3, 3));              // collinear
    tri_q.push_back(mk_tri(5, -7, 5, -7, 9, 9));            // repeated corner
    tri_q.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    tri_q.push_back(mk_tri(32767, 32767, -32768, 32767, 32767, -32768));
    tri_q.push_back(mk_tri(-32768, 32767, 32767, -32768, -32768, -32768));
    tri_q.push_back(mk_tri(-32768, -32768, 32767, 32767, 32767, 32766));  // sliver
    tri_q.push_back(mk_tri(-32768, -32768, 32767, 32767, -32768, 32767));
    tri_q.push_back(mk_tri(0, 0, 32767, 0, 32767, 1));       // thin, huge entries
    tri_q.push_back(mk_tri(0, 0, 1, 0, 32767, 1));
    tri_q.push_back(mk_tri(-1, -1, -1, -1, -1, -1));
    tri_q.push_back(mk_tri(0, 0, 3, 0, 0, 3));
    tri_q.push_back(mk_tri(0, 0, 1, 0, 1, 1));
    tri_q.push_back(mk_tri(0, 0, 2, 1, 1, 2));
    tri_q.push_back(mk_tri(-32768, 0, 32767, 0, 0, -32768));
    tri_q.push_back(mk_tri(-21846, 21845, 10923, -10923, 32767, -32768));
    for (int i = 0; i < N_RANDOM; i++) tri_q.push_back(rand_tri());
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (tri_q.size() == 0 && !s_axis_tvalid_i);
    wait (stiff_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (stiff_q.size() != 0) begin
      $error("%0d predicted results never arrived", stiff_q.size());
      n_err++;
    end
    $display("%0d triangles sent, %0d results checked", n_sent, n_got);
    $display("%0d degenerate, %0d with a saturated entry", n_degen, n_sat);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
